@@ rtl/lrcd_pkg.sv @@
`default_nettype none

package lrcd_pkg;

  // Header window depth: LRC, id, length, CRC low; CRC high is the byte being taken
  localparam int unsigned HDR_LEN = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_payload;
    logic [7:0] packet_id;
    logic [7:0] payload_length;
    logic       last;
    logic       crc_good;
  } result_t;

  // CRC16-CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Two's complement of the 8-bit sum
  function automatic logic [7:0] lrc8(input logic [7:0] sum);
    return 8'(~sum + 8'd1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/lrcd_rx_if.sv @@
`default_nettype none

interface lrcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/lrcd_res_if.sv @@
`default_nettype none

interface lrcd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_payload;
  logic [7:0] packet_id;
  logic [7:0] payload_length;
  logic       last;
  logic       crc_good;

  modport source (
    output valid, output payload_byte, output is_payload, output packet_id,
    output payload_length, output last, output crc_good, input ready
  );
  modport sink (
    input valid, input payload_byte, input is_payload, input packet_id,
    input payload_length, input last, input crc_good, output ready
  );
endinterface

`default_nettype wire

@@ rtl/lrcd_deframe_ctl.sv @@
`default_nettype none

module lrcd_deframe_ctl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       rx_byte_i,
  output logic             res_valid_o,
  output lrcd_pkg::result_t res_o
);
  import lrcd_pkg::*;

  logic [7:0]  win_q [HDR_LEN];
  logic [7:0]  win_d [HDR_LEN];
  logic [2:0]  fill_q, fill_d;
  logic        in_pkt_q, in_pkt_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] exp_crc_q, exp_crc_d;
  logic [15:0] crc_q, crc_d;

  logic [15:0] crc_next;
  logic [7:0]  left_dec;
  logic [7:0]  hdr_sum;
  logic        hdr_hit;

  assign crc_next = crc16_byte(crc_q, rx_byte_i);
  assign left_dec = left_q - 8'd1;
  assign hdr_sum  = win_q[1] + win_q[2] + win_q[3] + rx_byte_i;
  assign hdr_hit  = (lrc8(hdr_sum) == win_q[0]);

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    in_pkt_d    = in_pkt_q;
    id_d        = id_q;
    len_d       = len_q;
    left_d      = left_q;
    exp_crc_d   = exp_crc_q;
    crc_d       = crc_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (beat_i) begin
      if (in_pkt_q) begin
        crc_d                = crc_next;
        left_d               = left_dec;
        res_valid_o          = 1'b1;
        res_o.payload_byte   = rx_byte_i;
        res_o.is_payload     = 1'b1;
        res_o.packet_id      = id_q;
        res_o.payload_length = len_q;
        if (left_dec == 8'd0) begin
          // final payload byte: check CRC, return to hunting
          res_o.last     = 1'b1;
          res_o.crc_good = (crc_next == exp_crc_q);
          in_pkt_d       = 1'b0;
          fill_d         = '0;
          crc_d          = CRC_INIT;
        end
      end else if (fill_q < 3'(HDR_LEN)) begin
        win_d[fill_q[1:0]] = rx_byte_i;
        fill_d             = fill_q + 3'd1;
      end else if (hdr_hit) begin
        id_d      = win_q[1];
        len_d     = win_q[2];
        exp_crc_d = {rx_byte_i, win_q[3]};
        crc_d     = CRC_INIT;
        fill_d    = '0;
        if (win_q[2] == 8'd0) begin
          // empty packet ends on its header byte
          res_valid_o          = 1'b1;
          res_o.packet_id      = win_q[1];
          res_o.last           = 1'b1;
          res_o.crc_good       = ({rx_byte_i, win_q[3]} == CRC_INIT);
          left_d               = 8'd0;
        end else begin
          left_d   = win_q[2];
          in_pkt_d = 1'b1;
        end
      end else begin
        // slide the window by one byte
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = win_q[3];
        win_d[3] = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        win_q[i] <= '0;
      end
      fill_q    <= '0;
      in_pkt_q  <= 1'b0;
      id_q      <= '0;
      len_q     <= '0;
      left_q    <= '0;
      exp_crc_q <= '0;
      crc_q     <= CRC_INIT;
    end else begin
      win_q     <= win_d;
      fill_q    <= fill_d;
      in_pkt_q  <= in_pkt_d;
      id_q      <= id_d;
      len_q     <= len_d;
      left_q    <= left_d;
      exp_crc_q <= exp_crc_d;
      crc_q     <= crc_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lrcd_out_skid.sv @@
`default_nettype none

module lrcd_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lrcd_pkg::result_t push_res_i,
  output logic              space_o,
  output logic              out_valid_o,
  output lrcd_pkg::result_t out_res_o,
  input  logic              out_ready_i
);
  import lrcd_pkg::*;

  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    pop;

  assign pop         = out_valid_q & out_ready_i;
  assign space_o     = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d = push_res_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (!out_valid_q) begin
      if (push_i) begin
        out_d       = push_res_i;
        out_valid_d = 1'b1;
      end
    end else if (push_i) begin
      // receiver stalled: park the beat
      skid_d       = push_res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ rtl/lrc_crc16_packet_deframer_core.sv @@
// Packet deframer for a received byte stream.
// Input channel in_i: one received byte per beat (rx_byte).
// Output channel out_o: at most one result per input beat: a payload byte
// tagged with packet id and length, with last/crc_good on the closing beat.
// A packet is LRC, id, length, CRC low, CRC high, then length payload bytes.
// Hunting and header bytes produce no result; a zero-length packet produces
// one non-payload result with last set on its header byte.
// Throughput: one byte per cycle, sustained while in_i.ready is high. Header LRC, CRC16 byte update
// and all state updates are done in the accepting cycle.
// A result is registered in the output stage before it is valid on out_o.
// Stall: a two-entry output stage (output register plus skid register) lets
// in_i keep taking bytes while a result waits; in_i.ready drops only when
// both entries are full, and rises again once out_o takes a beat.
// Reset (rst_ni, async low): window empty, hunting, running CRC at 0xFFFF,
// output stage empty.
`default_nettype none

module lrc_crc16_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrcd_rx_if.sink     in_i,
  lrcd_res_if.source  out_o
);
  import lrcd_pkg::*;

  logic    beat;
  logic    res_valid;
  result_t res;
  logic    space;
  result_t out_res;

  // accept a byte whenever the output stage has a free entry
  assign in_i.ready = space;
  assign beat       = in_i.valid & space;

  lrcd_deframe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (in_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lrcd_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .space_o     (space),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.payload_byte   = out_res.payload_byte;
  assign out_o.is_payload     = out_res.is_payload;
  assign out_o.packet_id      = out_res.packet_id;
  assign out_o.payload_length = out_res.payload_length;
  assign out_o.last           = out_res.last;
  assign out_o.crc_good       = out_res.crc_good;

  // a non-payload result only closes an empty packet
  a_nonpayload_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_payload |-> out_o.last && out_o.payload_byte == 8'd0)
    else $error("non-payload result without last or with data");

  a_good_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.crc_good |-> out_o.last)
    else $error("crc_good set outside a closing beat");

  a_empty_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_payload |-> out_o.payload_length == 8'd0)
    else $error("empty-packet result with nonzero length");

  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input back-pressured with empty output register");

endmodule

`default_nettype wire
